>>> rtl/core/mlru_pkg.sv
// ---------------------------------------------------------------------------
// Matrix LRU package
// Shared constants, types and state codes for the matrix LRU page
// replacement block.
// ---------------------------------------------------------------------------
package mlru_pkg;

  // Geometry of the frame store and the address space.
  localparam int FRAMES     = 8;
  localparam int ADDR_BITS  = 16;
  localparam int PAGE_W     = 16;
  localparam int FRAME_W    = $clog2(FRAMES);
  localparam int SHIFT_W    = 4;

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_PAGE_SHIFT = 1'b0;
  localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RESET = SHIFT_W'(1);

  // Page queue between the front end and the replacement engine.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Queue status seen by both sides.
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // Replacement engine states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOOKUP,
    BK_WRITE
  } bk_state_t;

  // Control from the engine state machine to its datapath.
  typedef struct packed {
    logic pop;
    logic lookup;
    logic commit;
  } bk_ctrl_t;

endpackage

>>> rtl/core/mlru_queue.sv
// ---------------------------------------------------------------------------
// Matrix LRU page queue
// Short show-ahead queue of page numbers between the front end and the
// replacement engine.
// ---------------------------------------------------------------------------
module mlru_queue import mlru_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [PAGE_W-1:0] push_page,
  input  logic              pop,
  output logic [PAGE_W-1:0] head_page,
  output q_status_t         status
);

  logic [PAGE_W-1:0] entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  // Storage is written at the tail on every push.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_page;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head_page    = entries[rd_ptr];
  assign status.empty = (count == '0);
  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));

endmodule

>>> rtl/core/mlru_front.sv
// ---------------------------------------------------------------------------
// Matrix LRU front end
// Holds the page shift register, takes address transfers and turns each
// address into a page number for the queue.
// ---------------------------------------------------------------------------
module mlru_front import mlru_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  start,
  input  logic [ADDR_BITS-1:0]  address,
  output logic                  busy,
  input  q_status_t             q_status,
  output logic                  push,
  output logic [PAGE_W-1:0]     push_page
);

  logic [SHIFT_W-1:0] page_shift;
  logic               cfg_write;
  logic               reg_sel;

  // Register decode on the word address.
  assign reg_sel   = paddr[APB_ADDR_W-1];
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (reg_sel == REG_PAGE_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      page_shift <= PAGE_SHIFT_RESET;
    end else if (cfg_write) begin
      page_shift <= pwdata[SHIFT_W-1:0];
    end
  end

  // Read data for the only register; other addresses read as zero.
  always_comb begin
    prdata = '0;
    if (reg_sel == REG_PAGE_SHIFT) begin
      prdata = APB_DATA_W'(page_shift);
    end
  end

  // An address transfer completes whenever the queue has room.
  assign busy      = q_status.full;
  assign push      = start && !busy;
  assign push_page = PAGE_W'(address >> page_shift);

endmodule

>>> rtl/core/mlru_back.sv
// ---------------------------------------------------------------------------
// Matrix LRU replacement engine
// Looks up one page against the frame tags, picks the frame to use and
// updates tags, valid bits and the LRU matrix, then reports the result.
// ---------------------------------------------------------------------------
module mlru_back import mlru_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  q_status_t          q_status,
  input  logic [PAGE_W-1:0]  head_page,
  output logic               pop,
  output logic               done,
  output logic               hit,
  output logic [FRAME_W-1:0] frame,
  output logic [PAGE_W-1:0]  page,
  output logic               evict_valid,
  output logic [PAGE_W-1:0]  evicted_page
);

  bk_state_t state;
  bk_state_t state_next;
  bk_ctrl_t  ctrl;

  // Frame state.
  logic [PAGE_W-1:0] frame_tag [FRAMES];
  logic [FRAMES-1:0] frame_valid;
  logic [FRAMES-1:0] lru_row [FRAMES];

  // Item being worked on and the registered lookup result.
  logic [PAGE_W-1:0]  item_page;
  logic [FRAME_W-1:0] sel;
  logic               sel_hit;
  logic               sel_evict;
  logic [PAGE_W-1:0]  sel_evp;

  // Lookup logic.
  logic               any_hit;
  logic [FRAME_W-1:0] hit_idx;
  logic               any_empty;
  logic [FRAME_W-1:0] empty_idx;
  logic               any_zero;
  logic [FRAME_W-1:0] lru_idx;
  logic [FRAME_W-1:0] sel_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: a lookup state and a write state per item, the next item
  // is taken during the write state.
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!q_status.empty) state_next = BK_LOOKUP;
      end
      BK_LOOKUP: begin
        state_next = BK_WRITE;
      end
      BK_WRITE: begin
        state_next = q_status.empty ? BK_IDLE : BK_LOOKUP;
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // State machine outputs.
  always_comb begin
    ctrl = '0;
    case (state)
      BK_IDLE: begin
        ctrl.pop = !q_status.empty;
      end
      BK_LOOKUP: begin
        ctrl.lookup = 1'b1;
      end
      BK_WRITE: begin
        ctrl.commit = 1'b1;
        ctrl.pop    = !q_status.empty;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  assign pop = ctrl.pop;

  // Take the page at the head of the queue.
  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      item_page <= head_page;
    end
  end

  // Tag match; the lowest matching frame wins.
  always_comb begin
    any_hit = 1'b0;
    hit_idx = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (frame_valid[i] && (frame_tag[i] == item_page)) begin
        any_hit = 1'b1;
        hit_idx = FRAME_W'(i);
      end
    end
  end

  // Highest-numbered empty frame.
  always_comb begin
    any_empty = 1'b0;
    empty_idx = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (!frame_valid[i]) begin
        any_empty = 1'b1;
        empty_idx = FRAME_W'(i);
      end
    end
  end

  // Least recently used frame. Every valid frame has been touched, so with
  // all frames full the matrix holds a total order and exactly one row is
  // all zero: that row is the smallest one.
  always_comb begin
    any_zero = 1'b0;
    lru_idx  = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (lru_row[i] == '0) begin
        any_zero = 1'b1;
        lru_idx  = FRAME_W'(i);
      end
    end
  end

  always_comb begin
    if (any_hit) begin
      sel_next = hit_idx;
    end else if (any_empty) begin
      sel_next = empty_idx;
    end else begin
      sel_next = any_zero ? lru_idx : '0;
    end
  end

  // Register the lookup result.
  always_ff @(posedge clk) begin
    if (ctrl.lookup) begin
      sel       <= sel_next;
      sel_hit   <= any_hit;
      sel_evict <= !any_hit && !any_empty;
      sel_evp   <= (!any_hit && !any_empty) ? frame_tag[sel_next] : '0;
    end
  end

  // Tag store: a miss loads the page into the chosen frame.
  always_ff @(posedge clk) begin
    if (ctrl.commit && !sel_hit) begin
      frame_tag[sel] <= item_page;
    end
  end

  // Valid bits and LRU matrix: the chosen row goes to ones, its column to
  // zeros.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        lru_row[i] <= '0;
      end
    end else if (ctrl.commit) begin
      frame_valid[sel] <= 1'b1;
      for (int i = 0; i < FRAMES; i++) begin
        if (FRAME_W'(i) == sel) begin
          lru_row[i] <= ~(FRAMES'(1) << sel);
        end else begin
          lru_row[i] <= lru_row[i] & ~(FRAMES'(1) << sel);
        end
      end
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.commit;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      hit          <= sel_hit;
      frame        <= sel;
      page         <= item_page;
      evict_valid  <= sel_evict;
      evicted_page <= sel_evp;
    end
  end

endmodule

>>> rtl/core/matrix_lru_page_replacement.sv
// ---------------------------------------------------------------------------
// Matrix LRU page replacement
// Maps each accessed address to a page frame over eight frames, replacing
// the least recently used frame on a miss when no frame is empty.
// ---------------------------------------------------------------------------
// Flow: an address is pushed into the page queue, popped into the engine,
// looked up and written, then strobed on the registered result outputs.
// The engine pops the next item during its write state; busy rises while
// the two-entry page queue is full.
// Reset: frames empty, LRU matrix clear, page shift 1, no result pending.
module matrix_lru_page_replacement import mlru_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  start,
  input  logic [ADDR_BITS-1:0]  address,
  output logic                  busy,
  output logic                  done,
  output logic                  hit,
  output logic [FRAME_W-1:0]    frame,
  output logic [PAGE_W-1:0]     page,
  output logic                  evict_valid,
  output logic [PAGE_W-1:0]     evicted_page
);

  q_status_t         q_status;
  logic              push;
  logic [PAGE_W-1:0] push_page;
  logic              pop;
  logic [PAGE_W-1:0] head_page;

  // Front end: configuration and page number.
  mlru_front u_front (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .start     (start),
    .address   (address),
    .busy      (busy),
    .q_status  (q_status),
    .push      (push),
    .push_page (push_page)
  );

  // Page queue.
  mlru_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_page (push_page),
    .pop       (pop),
    .head_page (head_page),
    .status    (q_status)
  );

  // Replacement engine.
  mlru_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .head_page    (head_page),
    .pop          (pop),
    .done         (done),
    .hit          (hit),
    .frame        (frame),
    .page         (page),
    .evict_valid  (evict_valid),
    .evicted_page (evicted_page)
  );

endmodule

>>> rtl/core/mlru_checker.sv
// ---------------------------------------------------------------------------
// Matrix LRU checker
// Port-level checks on results and reset, bound to the top level.
// ---------------------------------------------------------------------------
module mlru_checker import mlru_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  busy,
  input logic                  done,
  input logic                  hit,
  input logic [PAGE_W-1:0]     page,
  input logic                  evict_valid,
  input logic [PAGE_W-1:0]     evicted_page
);

  // A hit never evicts anything.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> !evict_valid)
    else $error("hit result reports an eviction");

  // A replaced page is never the page that missed.
  a_evict_other_page: assert property (@(posedge clk) disable iff (rst)
    (done && evict_valid) |-> (evicted_page != page))
    else $error("evicted page equals the accessed page");

  // Each item passes a lookup state before its write state, so results never strobe back to back.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results in consecutive cycles");

  // Nothing is reported or blocked right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> (!done && !busy))
    else $error("result or busy right after reset");

endmodule

bind matrix_lru_page_replacement mlru_checker u_mlru_checker (.*);

>>> dv/tb_matrix_lru_page_replacement.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Matrix LRU page replacement testbench
// Drives byte addresses into the block under several page-shift settings
// and checks every strobed result against the directed table's expected
// value or a cycle-free model of the frame store and its LRU matrix. A
// short directed table comes first, then random accesses drawn mostly from
// a small set of pages, so that hits, empty-frame fills and LRU evictions all occur.
// ---------------------------------------------------------------------------
module tb_matrix_lru_page_replacement;
  import mlru_pkg::*;

  // Register map: register i lies at byte address 4*i.
  localparam logic [APB_ADDR_W-1:0] PAGE_SHIFT_ADDR = APB_ADDR_W'(4 * REG_PAGE_SHIFT);
  localparam logic [APB_ADDR_W-1:0] SPARE_ADDR      = APB_ADDR_W'(4);

  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 50;
  localparam int POOL_SIZE    = 12;
  localparam int DRAIN_CYCLES = 6;
  localparam int DRAIN_LIMIT  = 2000;

  // One result transfer.
  typedef struct packed {
    logic                 hit;
    logic [FRAME_W-1:0]   frame;
    logic [PAGE_W-1:0]    page;
    logic                 evict_valid;
    logic [PAGE_W-1:0]    evicted_page;
  } page_result_t;

  // One row of the directed table; want is used only where typed is set.
  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    logic                 typed;
    page_result_t         want;
  } access_row_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  start;
  logic [ADDR_BITS-1:0]  address;
  logic                  busy;
  logic                  done;
  logic                  hit;
  logic [FRAME_W-1:0]    frame;
  logic [PAGE_W-1:0]     page;
  logic                  evict_valid;
  logic [PAGE_W-1:0]     evicted_page;

  // Model state of the frame store.
  logic [SHIFT_W-1:0]    page_shift_q;
  logic [PAGE_W-1:0]     frame_page [FRAMES];
  logic                  frame_full [FRAMES];
  logic [FRAMES-1:0]     lru_rows   [FRAMES];

  page_result_t          pending_results [$];
  access_row_t           access_table [$];
  logic [PAGE_W-1:0]     page_pool [POOL_SIZE];

  int fail_count     = 0;
  int accesses_sent  = 0;
  int hits_seen      = 0;
  int evictions_seen = 0;
  int shift_settings = 0;

  matrix_lru_page_replacement DUT (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .start        (start),
    .address      (address),
    .busy         (busy),
    .done         (done),
    .hit          (hit),
    .frame        (frame),
    .page         (page),
    .evict_valid  (evict_valid),
    .evicted_page (evicted_page)
  );

  // Free-running clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Row value with column 0 as the most significant bit.
  function automatic logic [FRAMES-1:0] lru_rank(input int r);
    logic [FRAMES-1:0] v;
    v = '0;
    for (int j = 0; j < FRAMES; j++) begin
      v[FRAMES-1-j] = lru_rows[r][j];
    end
    return v;
  endfunction

  // Look up one address, update the frame store and return the result.
  function automatic page_result_t access_page(input logic [ADDR_BITS-1:0] addr);
    page_result_t      r;
    int                sel;
    logic [PAGE_W-1:0] pg;
    logic [FRAMES-1:0] best;
    r   = '0;
    sel = -1;
    pg  = PAGE_W'(addr >> page_shift_q);
    for (int i = 0; i < FRAMES; i++) begin
      if (sel < 0 && frame_full[i] && frame_page[i] == pg) begin
        sel   = i;
        r.hit = 1'b1;
      end
    end
    if (!r.hit) begin
      // Highest-numbered empty frame first, else the least recently used.
      for (int i = FRAMES - 1; i >= 0; i--) begin
        if (sel < 0 && !frame_full[i]) sel = i;
      end
      if (sel < 0) begin
        sel  = 0;
        best = lru_rank(0);
        for (int i = 1; i < FRAMES; i++) begin
          if (lru_rank(i) < best) begin
            best = lru_rank(i);
            sel  = i;
          end
        end
        r.evict_valid  = 1'b1;
        r.evicted_page = frame_page[sel];
      end
      frame_page[sel] = pg;
      frame_full[sel] = 1'b1;
    end
    // Mark the chosen frame most recently used.
    lru_rows[sel] = '1;
    for (int j = 0; j < FRAMES; j++) begin
      lru_rows[j][sel] = 1'b0;
    end
    r.frame = FRAME_W'(sel);
    r.page  = pg;
    return r;
  endfunction

  function automatic access_row_t table_row(input logic [ADDR_BITS-1:0] a,
                                            input logic typed, input logic h,
                                            input int f, input logic [PAGE_W-1:0] pg);
    access_row_t row;
    row       = '0;
    row.addr  = a;
    row.typed = typed;
    row.want  = '{hit: h, frame: FRAME_W'(f), page: pg, evict_valid: 1'b0,
                  evicted_page: '0};
    return row;
  endfunction

  // Present one address and hold it until the block takes the transfer.
  task automatic send_access(input logic [ADDR_BITS-1:0] a, input logic typed,
                             input page_result_t want);
    page_result_t predicted;
    @(negedge clk);
    start   <= 1'b1;
    address <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = access_page(a);
    pending_results.push_back(typed ? want : predicted);
    accesses_sent++;
  endtask

  task automatic idle_cycles(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic wait_drained();
    int cycles;
    cycles = 0;
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0 && cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [APB_ADDR_W-1:0] a,
                                input logic [APB_DATA_W-1:0] d);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (a == PAGE_SHIFT_ADDR) begin
      page_shift_q = d[SHIFT_W-1:0];
      shift_settings++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Read the page shift back and compare it with the model's copy.
  task automatic check_page_shift();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= PAGE_SHIFT_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[SHIFT_W-1:0] !== page_shift_q) begin
      $error("page_shift readback mismatch: expected %0d, actual %0d",
             page_shift_q, prdata[SHIFT_W-1:0]);
      fail_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    page_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no access outstanding: page %0h", page);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (hit !== want.hit) begin
          $error("hit mismatch: expected %0d, actual %0d", want.hit, hit);
          fail_count++;
        end
        if (frame !== want.frame) begin
          $error("frame mismatch: expected %0d, actual %0d", want.frame, frame);
          fail_count++;
        end
        if (page !== want.page) begin
          $error("page mismatch: expected %0h, actual %0h", want.page, page);
          fail_count++;
        end
        if (evict_valid !== want.evict_valid) begin
          $error("evict_valid mismatch: expected %0d, actual %0d",
                 want.evict_valid, evict_valid);
          fail_count++;
        end
        if (evicted_page !== want.evicted_page) begin
          $error("evicted_page mismatch: expected %0h, actual %0h",
                 want.evicted_page, evicted_page);
          fail_count++;
        end
        if (want.hit) hits_seen++;
        if (want.evict_valid) evictions_seen++;
      end
    end
  end

  // Main sequence.
  initial begin
    logic [ADDR_BITS-1:0] a;
    logic [ADDR_BITS-1:0] low_mask;
    logic [SHIFT_W-1:0]   phase_shift;
    logic [SHIFT_W-1:0]   shift_plan [PHASES];

    rst     = 1'b1;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    start   = 1'b0;
    address = '0;
    page_shift_q = PAGE_SHIFT_RESET;
    for (int i = 0; i < FRAMES; i++) begin
      frame_page[i] = '0;
      frame_full[i] = 1'b0;
      lru_rows[i]   = '0;
    end
    shift_plan = '{4'd0, 4'd12, 4'd15, 4'd13, 4'd14, 4'd3, 4'd0, 4'd7, 4'd1};

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed table at the reset page shift: fills from the top frame,
    // hits, addresses at both extremes, then evictions once all are full.
    access_table.push_back(table_row(16'h0000, 1'b1, 1'b0, 7, 16'h0000));
    access_table.push_back(table_row(16'h0001, 1'b1, 1'b1, 7, 16'h0000));
    access_table.push_back(table_row(16'hFFFF, 1'b1, 1'b0, 6, 16'h7FFF));
    access_table.push_back(table_row(16'hFFFE, 1'b1, 1'b1, 6, 16'h7FFF));
    access_table.push_back(table_row(16'h0002, 1'b0, 1'b0, 0, '0));
    access_table.push_back(table_row(16'h0004, 1'b0, 1'b0, 0, '0));
    access_table.push_back(table_row(16'h0006, 1'b0, 1'b0, 0, '0));
    access_table.push_back(table_row(16'h0008, 1'b0, 1'b0, 0, '0));
    access_table.push_back(table_row(16'h000A, 1'b0, 1'b0, 0, '0));
    access_table.push_back(table_row(16'h000C, 1'b0, 1'b0, 0, '0));
    access_table.push_back(table_row(16'h0100, 1'b0, 1'b0, 0, '0));
    access_table.push_back(table_row(16'h0200, 1'b0, 1'b0, 0, '0));
    access_table.push_back(table_row(16'h0003, 1'b0, 1'b0, 0, '0));
    access_table.push_back(table_row(16'h0300, 1'b0, 1'b0, 0, '0));
    access_table.push_back(table_row(16'h5555, 1'b0, 1'b0, 0, '0));
    access_table.push_back(table_row(16'hAAAA, 1'b0, 1'b0, 0, '0));
    access_table.push_back(table_row(16'h0101, 1'b0, 1'b0, 0, '0));
    access_table.push_back(table_row(16'h8000, 1'b0, 1'b0, 0, '0));
    access_table.push_back(table_row(16'h7FFF, 1'b0, 1'b0, 0, '0));

    check_page_shift();
    foreach (access_table[i]) begin
      send_access(access_table[i].addr, access_table[i].typed, access_table[i].want);
    end

    // Random phases, one page shift each, including zero and the largest values.
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      phase_shift = (p == 6) ? SHIFT_W'($urandom_range(0, 15)) : shift_plan[p];
      write_register(PAGE_SHIFT_ADDR, (APB_DATA_W'($urandom()) & 32'hFFFF_FFF0)
                     | APB_DATA_W'(phase_shift));
      check_page_shift();
      // A write beyond the register list must leave the page shift alone.
      if (p % 3 == 1) begin
        write_register(SPARE_ADDR, $urandom());
        check_page_shift();
      end
      low_mask = ADDR_BITS'((32'h1 << page_shift_q) - 1);
      for (int k = 0; k < POOL_SIZE; k++) page_pool[k] = PAGE_W'($urandom());

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 3) != 0) begin
          a = (page_pool[$urandom_range(0, POOL_SIZE - 1)] & ~low_mask)
              | (ADDR_BITS'($urandom()) & low_mask);
        end else begin
          a = ADDR_BITS'($urandom_range(0, 65535));
        end
        if (p == 1 && n == PHASE_ITEMS / 2) wait_drained();
        if (p < PHASES - 1 && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 8));
        send_access(a, 1'b0, '0);
      end
    end

    wait_drained();
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      fail_count++;
    end

    $display("Sent %0d page accesses over %0d page-shift writes and the reset setting.",
             accesses_sent, shift_settings);
    $display("Results checked included %0d hits and %0d LRU evictions.",
             hits_seen, evictions_seen);
    if (fail_count == 0) begin
      $display("matrix_lru_page_replacement verification clean");
    end else begin
      $display("matrix_lru_page_replacement verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("matrix_lru_page_replacement verification failed");
    $finish;
  end

endmodule
